>>> rtl/irc_tok_pkg.sv
// ============================================================================
// irc_tok_pkg
// Shared types and constants for the command line tokenizer.
// ============================================================================
`default_nettype none

package irc_tok_pkg;

  // Limit on kept parameters per line
  localparam int unsigned MaxParams = 15;
  localparam int unsigned CntW      = $clog2(MaxParams + 1);

  // Output queue depth (two words may be pushed in one cycle)
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Characters of interest
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7a;
  localparam logic [7:0] CaseOff = 8'h20;

  // Field kinds
  localparam logic [2:0] KindPrefix = 3'd0;
  localparam logic [2:0] KindName   = 3'd1;
  localparam logic [2:0] KindMiddle = 3'd2;
  localparam logic [2:0] KindTrail  = 3'd3;
  localparam logic [2:0] KindEnd    = 3'd4;

  // Tokenizer phase codes
  localparam logic [2:0] PhLead     = 3'd0;
  localparam logic [2:0] PhPrefix   = 3'd1;
  localparam logic [2:0] PhGapName  = 3'd2;
  localparam logic [2:0] PhName     = 3'd3;
  localparam logic [2:0] PhGapParam = 3'd4;
  localparam logic [2:0] PhMiddle   = 3'd5;
  localparam logic [2:0] PhTrail    = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
  } tok_in_t;

  typedef struct packed {
    logic [2:0] field_kind;
    logic [7:0] out_char;
    logic       has_char;
    logic       field_start;
    logic [3:0] param_index;
    logic [3:0] param_total;
    logic       param_overflow;
    logic       line_done;
  } tok_out_t;

  // Words produced by one step, pushed into the output queue
  typedef struct packed {
    logic [1:0] num;
    tok_out_t   word0;
    tok_out_t   word1;
  } tok_push_t;

endpackage

`default_nettype wire

>>> rtl/irc_tok_core.sv
// ============================================================================
// irc_tok_core
// Tokenizer state and the per-byte step: up to two result words per byte.
// ============================================================================
`default_nettype none

module irc_tok_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire irc_tok_pkg::tok_in_t  in_word_i,
  output irc_tok_pkg::tok_push_t     push_o
);
  import irc_tok_pkg::*;

  localparam logic [CntW-1:0] CntMax = CntW'(MaxParams);

  logic [2:0]      phase_q, phase_d;
  logic            in_part_q, in_part_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  logic [7:0] ch;
  logic [7:0] upper;
  logic       open_ok;
  logic       mid_run;
  logic       part_eff;
  logic       fld_vld;
  tok_out_t   fld;
  tok_out_t   end_word;

  assign ch      = in_word_i.data_byte;
  assign upper   = (ch >= ChLowA && ch <= ChLowZ) ? ch - CaseOff : ch;
  assign open_ok = !ovf_q && (count_q < CntMax);

  // Per-byte step
  always_comb begin
    phase_d   = phase_q;
    in_part_d = in_part_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    fld_vld   = 1'b0;
    fld       = '0;
    mid_run   = 1'b0;
    part_eff  = in_part_q;

    unique case (phase_q)
      PhPrefix: begin
        if (ch == ChSpace) begin
          phase_d = PhGapName;
        end else begin
          fld_vld         = 1'b1;
          fld.field_kind  = KindPrefix;
          fld.out_char    = ch;
          fld.has_char    = 1'b1;
        end
      end
      PhGapName: begin
        if (ch != ChSpace) begin
          fld_vld         = 1'b1;
          fld.field_kind  = KindName;
          fld.out_char    = upper;
          fld.has_char    = 1'b1;
          fld.field_start = 1'b1;
          phase_d         = PhName;
        end
      end
      PhName: begin
        if (ch == ChSpace) begin
          phase_d = PhGapParam;
        end else begin
          fld_vld         = 1'b1;
          fld.field_kind  = KindName;
          fld.out_char    = upper;
          fld.has_char    = 1'b1;
        end
      end
      PhGapParam: begin
        if (ch == ChColon) begin
          phase_d = PhTrail;
          if (open_ok) begin
            fld_vld         = 1'b1;
            fld.field_kind  = KindTrail;
            fld.field_start = 1'b1;
            fld.param_index = 4'(count_q);
            count_d         = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end else if (ch != ChSpace) begin
          // first byte of a middle token
          mid_run  = 1'b1;
          part_eff = 1'b0;
        end
      end
      PhMiddle: begin
        mid_run = 1'b1;
      end
      PhTrail: begin
        if (!ovf_q && count_q != '0) begin
          fld_vld         = 1'b1;
          fld.field_kind  = KindTrail;
          fld.out_char    = ch;
          fld.has_char    = 1'b1;
          fld.param_index = 4'(count_q - 1'b1);
        end
      end
      default: begin
        // leading space skip; unused code behaves the same
        if (ch == ChSpace) begin
          phase_d = PhLead;
        end else if (ch == ChColon) begin
          fld_vld         = 1'b1;
          fld.field_kind  = KindPrefix;
          fld.field_start = 1'b1;
          phase_d         = PhPrefix;
        end else begin
          fld_vld         = 1'b1;
          fld.field_kind  = KindName;
          fld.out_char    = upper;
          fld.has_char    = 1'b1;
          fld.field_start = 1'b1;
          phase_d         = PhName;
        end
      end
    endcase

    // Middle token: split at commas, drop empty parts
    if (mid_run) begin
      phase_d = PhMiddle;
      if (ch == ChSpace) begin
        phase_d   = PhGapParam;
        in_part_d = 1'b0;
      end else if (ch == ChComma) begin
        in_part_d = 1'b0;
      end else if (!part_eff) begin
        in_part_d = 1'b1;
        if (open_ok) begin
          fld_vld         = 1'b1;
          fld.field_kind  = KindMiddle;
          fld.out_char    = ch;
          fld.has_char    = 1'b1;
          fld.field_start = 1'b1;
          fld.param_index = 4'(count_q);
          count_d         = count_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end else if (!ovf_q && count_q != '0) begin
        fld_vld         = 1'b1;
        fld.field_kind  = KindMiddle;
        fld.out_char    = ch;
        fld.has_char    = 1'b1;
        fld.param_index = 4'(count_q - 1'b1);
      end
    end

    // End-of-line word uses the updated count
    end_word                = '0;
    end_word.field_kind     = KindEnd;
    end_word.param_total    = 4'(count_d);
    end_word.param_overflow = ovf_d;
    end_word.line_done      = 1'b1;

    if (in_word_i.line_end) begin
      phase_d   = PhLead;
      in_part_d = 1'b0;
      count_d   = '0;
      ovf_d     = 1'b0;
    end
  end

  // Pack results in order: field word, then end word
  always_comb begin
    push_o = '0;
    if (step_i) begin
      if (fld_vld) begin
        push_o.word0 = fld;
        push_o.word1 = end_word;
        push_o.num   = in_word_i.line_end ? 2'd2 : 2'd1;
      end else begin
        push_o.word0 = end_word;
        push_o.num   = in_word_i.line_end ? 2'd1 : 2'd0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhLead;
      in_part_q <= 1'b0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      in_part_q <= in_part_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("parameter count above limit");
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> count_q == CntMax)
    else $error("overflow flagged with free parameter slots");
  a_part_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_part_q |-> phase_q == PhMiddle)
    else $error("part flag set outside middle token");
  a_line_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && in_word_i.line_end |=> phase_q == PhLead && count_q == '0 && !ovf_q)
    else $error("state not cleared after line end");
`endif

endmodule

`default_nettype wire

>>> rtl/irc_tok_fifo.sv
// ============================================================================
// irc_tok_fifo
// Small result queue: up to two words in per cycle, one word out per cycle while out_ready_i is high.
// ============================================================================
`default_nettype none

module irc_tok_fifo (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire irc_tok_pkg::tok_push_t push_i,
  output logic                        room2_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output irc_tok_pkg::tok_out_t       out_word_o
);
  import irc_tok_pkg::*;

  tok_out_t          mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              pop;
  logic [QPtrW-1:0]  wr_ptr1;

  assign out_valid_o = cnt_q != '0;
  assign out_word_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room2_o     = cnt_q <= QCntW'(QDepth - 2);
  assign wr_ptr1     = wr_ptr_q + 1'b1;

  // Storage writes
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.word0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr1] <= push_i.word1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_i.num);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCntW'(push_i.num) - QCntW'(pop);
    end
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count above depth");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> room2_o)
    else $error("push into queue without room");
  a_push_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd3)
    else $error("bad push count");
`endif

endmodule

`default_nettype wire

>>> rtl/irc_message_line_tokenizer.sv
// ============================================================================
// irc_message_line_tokenizer
// Splits a command line, one byte per word, into tagged field characters.
// ============================================================================
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   tok_in_t  (data_byte, line_end)
// out       output     out_valid_o/out_ready_i tok_out_t (one field or end word)
//
// One byte per cycle while the queue has room: a byte sits in the input
// register, is tokenized there and lands in a four-word result queue.
// A byte gives up to two words (a line_end byte adds the end word); the
// single-word output port then sets the rate for such bytes.
// A byte leaves the input register only when the queue has room for two.
// Reset clears the tokenizer state, the input register valid and the queue.
`default_nettype none

module irc_message_line_tokenizer (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire irc_tok_pkg::tok_in_t  in_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output irc_tok_pkg::tok_out_t      out_word_o
);
  import irc_tok_pkg::*;

  logic      in_valid_q;
  tok_in_t   in_word_q;
  logic      room2;
  logic      step;
  tok_push_t push;

  assign step       = in_valid_q && room2;
  assign in_ready_o = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  irc_tok_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .in_word_i (in_word_q),
    .push_o    (push)
  );

  irc_tok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

>>> tb/irc_message_line_tokenizer_test.sv
// ----------------------------------------------------------------------------
// irc_message_line_tokenizer_test
// Self-checking bench for the command line tokenizer. A short scripted set of
// lines covers markers, case folding, comma splits and byte extremes. Random
// lines follow, most of them well formed and some pure noise, under three
// idle mixes. Every word leaving the block is checked against the script's
// typed rows or against a behavioral tokenizer kept in this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module irc_message_line_tokenizer_test;
  import irc_tok_pkg::*;

  localparam int ScriptLen     = 25;
  localparam int ItemsPerPhase = 235;
  localparam int HoldCycles    = 300;
  localparam int WatchLimit    = 4000;
  localparam int SettleCycles  = 20;

  // One scripted byte; typed rows carry their own expected words
  typedef struct packed {
    tok_in_t    word;
    logic       typed;
    logic [1:0] typed_n;
    tok_out_t   typed0;
    tok_out_t   typed1;
  } script_row_t;

  localparam tok_out_t NoWord     = '0;
  localparam tok_out_t EndBare    = {KindEnd, 8'h00, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0, 1'b1};
  localparam tok_out_t PrefixMark = {KindPrefix, 8'h00, 1'b0, 1'b1, 4'd0, 4'd0, 1'b0, 1'b0};
  localparam tok_out_t PrefixTop  = {KindPrefix, 8'hff, 1'b1, 1'b0, 4'd0, 4'd0, 1'b0, 1'b0};
  localparam tok_out_t PrefixNul  = {KindPrefix, 8'h00, 1'b1, 1'b0, 4'd0, 4'd0, 1'b0, 1'b0};
  localparam tok_out_t NameUpA    = {KindName, "A", 1'b1, 1'b1, 4'd0, 4'd0, 1'b0, 1'b0};
  localparam tok_out_t TrailMark2 = {KindTrail, 8'h00, 1'b0, 1'b1, 4'd2, 4'd0, 1'b0, 1'b0};

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  tok_in_t  in_word_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  tok_out_t out_word_o;

  // Scripted lines: empty line, bare prefix, prefix extremes, name folding,
  // comma splits with empty parts, trailing with spaces, name at line end
  script_row_t script_rows [ScriptLen] = '{
    {ChSpace, 1'b1, 1'b1, 2'd1, EndBare, NoWord},
    {ChColon, 1'b1, 1'b1, 2'd2, PrefixMark, EndBare},
    {ChColon, 1'b0, 1'b1, 2'd1, PrefixMark, NoWord},
    {8'hff,   1'b0, 1'b1, 2'd1, PrefixTop, NoWord},
    {8'h00,   1'b0, 1'b1, 2'd1, PrefixNul, NoWord},
    {ChSpace, 1'b0, 1'b1, 2'd0, NoWord, NoWord},
    {ChLowA,  1'b0, 1'b1, 2'd1, NameUpA, NoWord},
    {ChLowZ,  1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {8'h7b,   1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {ChSpace, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {ChSpace, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {ChComma, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {"x",     1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {ChComma, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {ChComma, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {8'h60,   1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {"q",     1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {ChSpace, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {ChColon, 1'b0, 1'b1, 2'd1, TrailMark2, NoWord},
    {ChSpace, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {ChColon, 1'b1, 1'b0, 2'd0, NoWord, NoWord},
    {"b",     1'b1, 1'b0, 2'd0, NoWord, NoWord},
    {"c",     1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {ChSpace, 1'b0, 1'b0, 2'd0, NoWord, NoWord},
    {ChColon, 1'b1, 1'b0, 2'd0, NoWord, NoWord}
  };

  // Bench state
  tok_out_t    awaited_words [$];
  tok_out_t    step_words [$];
  logic [7:0]  line_bytes [$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  int          hold_asks      = 0;

  // Tokenizer state mirrored in the bench
  logic [2:0]  tok_phase;
  logic        tok_in_part;
  int unsigned tok_count;
  logic        tok_overflow;

  irc_message_line_tokenizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- queues
  function automatic void add_step_word(tok_out_t w);
    step_words = {step_words, w};
  endfunction

  function automatic void add_awaited(tok_out_t w);
    awaited_words = {awaited_words, w};
  endfunction

  function automatic void add_line_byte(logic [7:0] b);
    line_bytes = {line_bytes, b};
  endfunction

  // ---------------------------------------------------------------- tokenizer
  function automatic void reset_tokenizer();
    tok_phase    = PhLead;
    tok_in_part  = 1'b0;
    tok_count    = 0;
    tok_overflow = 1'b0;
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= ChLowA && c <= ChLowZ) ? c - CaseOff : c;
  endfunction

  function automatic tok_out_t field_word(logic [2:0] kind, logic [7:0] ch, logic has,
                                          logic start, int unsigned idx);
    tok_out_t w;
    w             = '0;
    w.field_kind  = kind;
    w.out_char    = ch;
    w.has_char    = has;
    w.field_start = start;
    w.param_index = idx[3:0];
    return w;
  endfunction

  // Count a new parameter unless the line is already full
  function automatic bit claim_param(output int unsigned idx);
    idx = 0;
    if (tok_overflow || tok_count >= MaxParams) begin
      tok_overflow = 1'b1;
      return 1'b0;
    end
    idx = tok_count;
    tok_count++;
    return 1'b1;
  endfunction

  function automatic void middle_byte(logic [7:0] c);
    int unsigned idx;
    if (c == ChSpace) begin
      tok_phase   = PhGapParam;
      tok_in_part = 1'b0;
    end else if (c == ChComma) begin
      tok_in_part = 1'b0;
    end else if (!tok_in_part) begin
      tok_in_part = 1'b1;
      if (claim_param(idx)) add_step_word(field_word(KindMiddle, c, 1'b1, 1'b1, idx));
    end else if (!tok_overflow && tok_count > 0) begin
      add_step_word(field_word(KindMiddle, c, 1'b1, 1'b0, tok_count - 1));
    end
  endfunction

  // Words caused by one input byte, appended to step_words
  function automatic void tokenize_byte(tok_in_t w);
    logic [7:0]  c;
    int unsigned idx;
    tok_out_t    fin;
    c = w.data_byte;
    case (tok_phase)
      PhPrefix: begin
        if (c == ChSpace) tok_phase = PhGapName;
        else add_step_word(field_word(KindPrefix, c, 1'b1, 1'b0, 0));
      end
      PhGapName: begin
        if (c != ChSpace) begin
          add_step_word(field_word(KindName, fold_case(c), 1'b1, 1'b1, 0));
          tok_phase = PhName;
        end
      end
      PhName: begin
        if (c == ChSpace) tok_phase = PhGapParam;
        else add_step_word(field_word(KindName, fold_case(c), 1'b1, 1'b0, 0));
      end
      PhGapParam: begin
        if (c == ChColon) begin
          tok_phase = PhTrail;
          if (claim_param(idx))
            add_step_word(field_word(KindTrail, 8'h00, 1'b0, 1'b1, idx));
        end else if (c != ChSpace) begin
          tok_phase   = PhMiddle;
          tok_in_part = 1'b0;
          middle_byte(c);
        end
      end
      PhMiddle: begin
        middle_byte(c);
      end
      PhTrail: begin
        if (!tok_overflow && tok_count > 0)
          add_step_word(field_word(KindTrail, c, 1'b1, 1'b0, tok_count - 1));
      end
      default: begin
        // leading space skip, also taken by the unused phase code
        if (c == ChColon) begin
          add_step_word(field_word(KindPrefix, 8'h00, 1'b0, 1'b1, 0));
          tok_phase = PhPrefix;
        end else if (c != ChSpace) begin
          add_step_word(field_word(KindName, fold_case(c), 1'b1, 1'b1, 0));
          tok_phase = PhName;
        end
      end
    endcase
    if (w.line_end) begin
      fin                = '0;
      fin.field_kind     = KindEnd;
      fin.param_total    = tok_count[3:0];
      fin.param_overflow = tok_overflow;
      fin.line_done      = 1'b1;
      add_step_word(fin);
      reset_tokenizer();
    end
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_byte(input script_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= row.word;
    do @(posedge clk_i); while (!in_ready_o);
    step_words.delete();
    tokenize_byte(row.word);
    if (row.typed) begin
      if (row.typed_n > 0) add_awaited(row.typed0);
      if (row.typed_n > 1) add_awaited(row.typed1);
    end else begin
      foreach (step_words[i]) add_awaited(step_words[i]);
    end
  endtask

  // Sender pause until every awaited word is out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_words.size() != 0);
  endtask

  function automatic logic [7:0] token_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == ChSpace || c == ChComma || c == ChColon);
    if ($urandom_range(3) == 0) c = ChLowA + 8'($urandom_range(25));
    return c;
  endfunction

  // Build one random line: mostly well formed, some noise
  task automatic compose_line(input bit many_params);
    int n_params;
    int n_parts;
    line_bytes.delete();
    if (!many_params && $urandom_range(99) < 15) begin
      repeat ($urandom_range(12, 1)) begin
        case ($urandom_range(3))
          0:       add_line_byte(ChSpace);
          1:       add_line_byte(ChColon);
          2:       add_line_byte(ChComma);
          default: add_line_byte(8'($urandom_range(255)));
        endcase
      end
    end else begin
      repeat ($urandom_range(2)) add_line_byte(ChSpace);
      if ($urandom_range(2) == 0) begin
        add_line_byte(ChColon);
        repeat ($urandom_range(4)) add_line_byte(token_char());
        add_line_byte(ChSpace);
      end
      repeat ($urandom_range(1)) add_line_byte(ChSpace);
      repeat ($urandom_range(6)) add_line_byte(token_char());
      if (many_params) n_params = $urandom_range(20, 16);
      else if ($urandom_range(9) == 0) n_params = $urandom_range(18, 13);
      else n_params = $urandom_range(5);
      for (int p = 0; p < n_params; p++) begin
        repeat ($urandom_range(2, 1)) add_line_byte(ChSpace);
        if (p == n_params - 1 && $urandom_range(2) == 0) begin
          add_line_byte(ChColon);
          repeat ($urandom_range(6))
            add_line_byte(($urandom_range(3) == 0) ? ChSpace : token_char());
        end else begin
          n_parts = many_params ? 1 : $urandom_range(3, 1);
          for (int k = 0; k < n_parts; k++) begin
            if (k > 0) add_line_byte(ChComma);
            if ($urandom_range(4) == 0) add_line_byte(ChComma);
            repeat ($urandom_range(4, 1)) add_line_byte(token_char());
          end
        end
      end
      if ($urandom_range(4) == 0) add_line_byte(ChSpace);
    end
    if (line_bytes.size() == 0) add_line_byte(8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    script_row_t row;
    int          phase_items;
    bit          first_line;
    reset_tokenizer();
    send_idle_pct = 35;
    recv_idle_pct = 86;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < ScriptLen; i++) send_byte(script_rows[i]);
    drain_results();

    first_line = 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // receiver stalls long while bytes keep coming
          hold_asks++;
        end
      endcase
      phase_items = 0;
      while (phase_items < ItemsPerPhase) begin
        compose_line(first_line);
        first_line = 1'b0;
        foreach (line_bytes[i]) begin
          row           = '0;
          row.word      = {line_bytes[i], 1'b0};
          row.word.line_end = (i == line_bytes.size() - 1);
          send_byte(row);
        end
        phase_items += line_bytes.size();
      end
      drain_results();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_words.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checker
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_words
    tok_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, out_word_o);
        mismatch_count++;
      end else begin
        want = awaited_words.pop_front();
        check_field("field_kind", want.field_kind, out_word_o.field_kind);
        check_field("out_char", want.out_char, out_word_o.out_char);
        check_field("has_char", want.has_char, out_word_o.has_char);
        check_field("field_start", want.field_start, out_word_o.field_start);
        check_field("param_index", want.param_index, out_word_o.param_index);
        check_field("param_total", want.param_total, out_word_o.param_total);
        check_field("param_overflow", want.param_overflow, out_word_o.param_overflow);
        check_field("line_done", want.line_done, out_word_o.line_done);
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin : watchdog
    int idle_cycles;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, WatchLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule

>>> files.f
rtl/irc_tok_pkg.sv
rtl/irc_tok_core.sv
rtl/irc_tok_fifo.sv
rtl/irc_message_line_tokenizer.sv
tb/irc_message_line_tokenizer_test.sv
